/* rtl/lrast_pkg.sv */
// Shared types and constants for the line rasterizer.
// Used by lrast_front, lrast_back, line_rasterizer_unit and lrast_checker.
// No dependencies.
package lrast_pkg;

    localparam int unsigned SCREEN_WIDTH = 240;
    localparam int unsigned COORD_W      = 8;
    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned COLOR_W      = 16;
    localparam int unsigned ERR_W        = 9;

    // Command codes of an input item.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // Signed unit steps.
    localparam logic [1:0] STEP_ZERO = 2'b00;
    localparam logic [1:0] STEP_POS  = 2'b01;
    localparam logic [1:0] STEP_NEG  = 2'b11;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_start;
        logic [COORD_W-1:0] x_end;
        logic [COORD_W-1:0] y_end;
        logic [COLOR_W-1:0] color;
    } lrast_in_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [ADDR_W-1:0]  pixel_addr;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } lrast_pix_t;

    // Decoded command passed from the front end to the step engine.
    typedef struct packed {
        logic               is_start;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] long_len;
        logic [COORD_W-1:0] short_len;
        logic [1:0]         diag_sx;
        logic [1:0]         diag_sy;
        logic [1:0]         straight_sx;
        logic [1:0]         straight_sy;
        logic [COLOR_W-1:0] color;
    } lrast_cmd_t;

endpackage

/* rtl/lrast_front.sv */
// Front end of the line rasterizer: accepts items, decodes start setup
// (steps, axis lengths) and holds decoded commands in a two-entry queue.
// Depends on lrast_pkg.
module lrast_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  lrast_pkg::lrast_in_t   req,
    output logic                   cmd_valid,
    output lrast_pkg::lrast_cmd_t  cmd,
    input  logic                   cmd_take
);

    lrast_pkg::lrast_cmd_t             dec;
    logic [lrast_pkg::COORD_W-1:0]     adx;
    logic [lrast_pkg::COORD_W-1:0]     ady;
    logic [1:0]                        sx;
    logic [1:0]                        sy;
    logic                              x_long;

    lrast_pkg::lrast_cmd_t             mem_reg [2];
    logic                              wr_ptr_reg;
    logic                              wr_ptr_next;
    logic                              rd_ptr_reg;
    logic                              rd_ptr_next;
    logic [1:0]                        count_reg;
    logic [1:0]                        count_next;
    logic                              do_push;
    logic                              do_take;

    always_comb
    begin
        adx = (req.x_start > req.x_end) ? req.x_start - req.x_end : req.x_end - req.x_start;
        ady = (req.y_start > req.y_end) ? req.y_start - req.y_end : req.y_end - req.y_start;

        if (req.x_end > req.x_start)
            sx = lrast_pkg::STEP_POS;
        else if (req.x_end < req.x_start)
            sx = lrast_pkg::STEP_NEG;
        else
            sx = lrast_pkg::STEP_ZERO;

        if (req.y_end > req.y_start)
            sy = lrast_pkg::STEP_POS;
        else if (req.y_end < req.y_start)
            sy = lrast_pkg::STEP_NEG;
        else
            sy = lrast_pkg::STEP_ZERO;

        // On equal lengths the y axis is the long one.
        x_long = (adx > ady);

        dec.is_start    = (req.cmd == lrast_pkg::CMD_START);
        dec.x0          = req.x_start;
        dec.y0          = req.y_start;
        dec.long_len    = x_long ? adx : ady;
        dec.short_len   = x_long ? ady : adx;
        dec.diag_sx     = sx;
        dec.diag_sy     = sy;
        dec.straight_sx = x_long ? sx : lrast_pkg::STEP_ZERO;
        dec.straight_sy = x_long ? lrast_pkg::STEP_ZERO : sy;
        dec.color       = req.color;
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_take   = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_take ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
            count_next = count_reg + 2'd1;
        else if (!do_push && do_take)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= dec;
    end

endmodule

/* rtl/lrast_back.sv */
// Step engine of the line rasterizer: holds the active line, advances it
// one pixel per tick and queues pixels in a two-entry output queue.
// Depends on lrast_pkg.
module lrast_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  lrast_pkg::lrast_cmd_t  cmd,
    output logic                   cmd_take,
    output logic                   empty,
    input  logic                   pop,
    output lrast_pkg::lrast_pix_t  pixel
);

    logic                              busy_reg;
    logic                              busy_next;
    logic [lrast_pkg::COORD_W-1:0]     cur_x_reg;
    logic [lrast_pkg::COORD_W-1:0]     cur_x_next;
    logic [lrast_pkg::COORD_W-1:0]     cur_y_reg;
    logic [lrast_pkg::COORD_W-1:0]     cur_y_next;
    logic [lrast_pkg::ERR_W-1:0]       err_reg;
    logic [lrast_pkg::ERR_W-1:0]       err_next;
    logic [lrast_pkg::COORD_W-1:0]     long_reg;
    logic [lrast_pkg::COORD_W-1:0]     long_next;
    logic [lrast_pkg::COORD_W-1:0]     short_reg;
    logic [lrast_pkg::COORD_W-1:0]     short_next;
    logic [lrast_pkg::COORD_W-1:0]     left_reg;
    logic [lrast_pkg::COORD_W-1:0]     left_next;
    logic [1:0]                        dsx_reg;
    logic [1:0]                        dsx_next;
    logic [1:0]                        dsy_reg;
    logic [1:0]                        dsy_next;
    logic [1:0]                        ssx_reg;
    logic [1:0]                        ssx_next;
    logic [1:0]                        ssy_reg;
    logic [1:0]                        ssy_next;
    logic [lrast_pkg::COLOR_W-1:0]     color_reg;
    logic [lrast_pkg::COLOR_W-1:0]     color_next;

    logic [lrast_pkg::ERR_W-1:0]       err_sum;
    logic                              diag;
    logic [1:0]                        step_x;
    logic [1:0]                        step_y;
    logic                              emit;
    lrast_pkg::lrast_pix_t             pix;

    lrast_pkg::lrast_pix_t             oq_reg [2];
    logic                              wr_ptr_reg;
    logic                              wr_ptr_next;
    logic                              rd_ptr_reg;
    logic                              rd_ptr_next;
    logic [1:0]                        count_reg;
    logic [1:0]                        count_next;
    logic                              do_pop;

    // A command is taken only when the output queue has room for a pixel.
    assign cmd_take = cmd_valid && (count_reg != 2'd2);
    assign emit     = cmd_take && !cmd.is_start && busy_reg;

    always_comb
    begin
        err_sum = lrast_pkg::ERR_W'(err_reg + {1'b0, short_reg});
        diag    = (err_sum >= {1'b0, long_reg});
        step_x  = diag ? dsx_reg : ssx_reg;
        step_y  = diag ? dsy_reg : ssy_reg;

        pix.pixel_x     = cur_x_reg;
        pix.pixel_y     = cur_y_reg;
        pix.pixel_addr  = lrast_pkg::ADDR_W'(
                              lrast_pkg::ADDR_W'(cur_y_reg)
                              * lrast_pkg::ADDR_W'(lrast_pkg::SCREEN_WIDTH))
                          + lrast_pkg::ADDR_W'(cur_x_reg);
        pix.pixel_color = color_reg;
        pix.last_pixel  = (left_reg == '0);

        busy_next  = busy_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        err_next   = err_reg;
        long_next  = long_reg;
        short_next = short_reg;
        left_next  = left_reg;
        dsx_next   = dsx_reg;
        dsy_next   = dsy_reg;
        ssx_next   = ssx_reg;
        ssy_next   = ssy_reg;
        color_next = color_reg;

        if (cmd_take && cmd.is_start)
        begin
            busy_next  = 1'b1;
            cur_x_next = cmd.x0;
            cur_y_next = cmd.y0;
            err_next   = lrast_pkg::ERR_W'(cmd.long_len >> 1);
            long_next  = cmd.long_len;
            short_next = cmd.short_len;
            left_next  = cmd.long_len;
            dsx_next   = cmd.diag_sx;
            dsy_next   = cmd.diag_sy;
            ssx_next   = cmd.straight_sx;
            ssy_next   = cmd.straight_sy;
            color_next = cmd.color;
        end
        else if (emit)
        begin
            err_next   = diag ? lrast_pkg::ERR_W'(err_sum - {1'b0, long_reg}) : err_sum;
            cur_x_next = cur_x_reg + {{(lrast_pkg::COORD_W-2){step_x[1]}}, step_x};
            cur_y_next = cur_y_reg + {{(lrast_pkg::COORD_W-2){step_y[1]}}, step_y};
            if (left_reg == '0)
                busy_next = 1'b0;
            else
                left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cur_x_reg <= '0;
            cur_y_reg <= '0;
            err_reg   <= '0;
            long_reg  <= '0;
            short_reg <= '0;
            left_reg  <= '0;
            dsx_reg   <= lrast_pkg::STEP_ZERO;
            dsy_reg   <= lrast_pkg::STEP_ZERO;
            ssx_reg   <= lrast_pkg::STEP_ZERO;
            ssy_reg   <= lrast_pkg::STEP_ZERO;
            color_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
            long_reg  <= long_next;
            short_reg <= short_next;
            left_reg  <= left_next;
            dsx_reg   <= dsx_next;
            dsy_reg   <= dsy_next;
            ssx_reg   <= ssx_next;
            ssy_reg   <= ssy_next;
            color_reg <= color_next;
        end
    end

    // Output queue.
    assign empty  = (count_reg == 2'd0);
    assign pixel  = oq_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = emit ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (emit && !do_pop)
            count_next = count_reg + 2'd1;
        else if (!emit && do_pop)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            oq_reg[wr_ptr_reg] <= pix;
    end

endmodule

/* rtl/line_rasterizer_unit.sv */
// Bresenham line rasterizer. It takes one item per clock while not full:
// a start item sets up a new line and gives no pixel, and each tick item
// while a line is active gives one pixel (column, row, row * 240 + column
// address, color, last flag). A line whose longer axis spans L steps
// gives L + 1 pixels. A tick waits in the input queue; its pixel is
// registered into the output queue once that has room. The step engine
// advances the position once per cycle while a tick waits and the output
// queue has room; two-entry queues on each side let both sides stall
// independently. Depends on lrast_pkg, lrast_front and lrast_back.
module line_rasterizer_unit
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  lrast_pkg::lrast_in_t   req,
    output logic                   empty,
    input  logic                   pop,
    output lrast_pkg::lrast_pix_t  pixel
);

    logic                   cmd_valid;
    logic                   cmd_take;
    lrast_pkg::lrast_cmd_t  cmd;

    lrast_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    lrast_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .pixel     (pixel)
    );

endmodule

/* rtl/lrast_checker.sv */
// Port-level checks for line_rasterizer_unit, attached by a bind statement.
// Depends on lrast_pkg.
module lrast_checker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  logic                   empty,
    input  logic                   pop,
    input  lrast_pkg::lrast_pix_t  pixel
);

    // Queues come out of reset empty.
    assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // A waiting pixel holds until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(pixel))
        else $error("waiting pixel changed");

    // The input queue only fills through a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("full rose without a push");

    // The address always matches the coordinates shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> pixel.pixel_addr == lrast_pkg::ADDR_W'(
            lrast_pkg::ADDR_W'(pixel.pixel_y)
            * lrast_pkg::ADDR_W'(lrast_pkg::SCREEN_WIDTH)
            + lrast_pkg::ADDR_W'(pixel.pixel_x)))
        else $error("pixel address does not match coordinates");

endmodule

bind line_rasterizer_unit lrast_checker u_lrast_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .pixel (pixel)
);
